[rtl/core/flight_phase_detector_macros.svh]
// Assertion macros for the flight phase detector RTL.
// Depends on nothing; the including module must have clock and reset.
`ifndef FLIGHT_PHASE_DETECTOR_MACROS_SVH
`define FLIGHT_PHASE_DETECTOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, off during reset
`define FPD_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("flight_phase_detector: assertion failed");
// next-cycle implication, off during reset
`define FPD_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("flight_phase_detector: assertion failed");
`else
`define FPD_ASSERT_IMPL(name, ante, cons)
`define FPD_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[rtl/core/fpd_pkg.sv]
// Package for the flight phase detector: phase and register codes, constants.
// Depends on nothing.
package fpd_pkg;

   localparam int ALT_BITS_DEF     = 20;
   localparam int FALL_RUN_LEN_DEF = 3;

   localparam int RISE_CM   = 50;
   localparam int FALL_CM   = 50;
   localparam int STABLE_CM = 30;
   localparam int PERMILLE_SCALE = 1000;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      PH_PAD     = 3'd0,
      PH_ASCENT  = 3'd1,
      PH_APOGEE  = 3'd2,
      PH_DESCENT = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_PROBE   = 3'd5,
      PH_LANDED  = 3'd6
   } phase_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_ARMED     = 3'd0,
      REG_LAUNCH    = 3'd1,
      REG_APO_WIN   = 3'd2,
      REG_PERMILLE  = 3'd3,
      REG_PRB_TGT   = 3'd4,
      REG_PRB_MRG   = 3'd5,
      REG_LAND_ALT  = 3'd6,
      REG_LAND_WIN  = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic        armed;
      logic [18:0] launch_cm;
      logic [31:0] apogee_win_ms;
      logic [9:0]  permille;
      logic [18:0] probe_tgt_cm;
      logic [18:0] probe_mrg_cm;
      logic [18:0] landed_cm;
      logic [31:0] landed_win_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      armed:         1'b0,
      launch_cm:     19'd1000,
      apogee_win_ms: 32'd2000,
      permille:      10'd800,
      probe_tgt_cm:  19'd200,
      probe_mrg_cm:  19'd50,
      landed_cm:     19'd500,
      landed_win_ms: 32'd3000
   };

endpackage

[rtl/core/fpd_csr.sv]
// Configuration register file of the flight phase detector.
// Depends on fpd_pkg.
module fpd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fpd_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [fpd_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output fpd_pkg::cfg_type                     cfg
);

   fpd_pkg::cfg_type cfg_ff;
   fpd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (fpd_pkg::csr_reg_type'(csr_index))
            fpd_pkg::REG_ARMED:    cfg_in.armed         = csr_data[0];
            fpd_pkg::REG_LAUNCH:   cfg_in.launch_cm     = csr_data[18:0];
            fpd_pkg::REG_APO_WIN:  cfg_in.apogee_win_ms = csr_data[31:0];
            fpd_pkg::REG_PERMILLE: cfg_in.permille      = csr_data[9:0];
            fpd_pkg::REG_PRB_TGT:  cfg_in.probe_tgt_cm  = csr_data[18:0];
            fpd_pkg::REG_PRB_MRG:  cfg_in.probe_mrg_cm  = csr_data[18:0];
            fpd_pkg::REG_LAND_ALT: cfg_in.landed_cm     = csr_data[18:0];
            fpd_pkg::REG_LAND_WIN: cfg_in.landed_win_ms = csr_data[31:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= fpd_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/core/fpd_step.sv]
// Flight state registers and the combinational step rule of the phase detector.
// Depends on fpd_pkg.
module fpd_step #(
   parameter int ALT_BITS     = fpd_pkg::ALT_BITS_DEF,
   parameter int FALL_RUN_LEN = fpd_pkg::FALL_RUN_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fpd_pkg::cfg_type            cfg,
   input  logic                        fire,
   input  logic                        mode,
   input  logic signed [ALT_BITS-1:0]  alt,
   input  logic signed [ALT_BITS+10:0] alt_k,
   input  logic [31:0]                 now,
   input  logic [2:0]                  forced,
   output fpd_pkg::phase_type          phase_in,
   output fpd_pkg::phase_type          prior_in,
   output logic                        changed_in,
   output logic                        pay_in,
   output logic                        prb_in,
   output logic signed [ALT_BITS-1:0]  peak_in
);

   localparam int PW = ALT_BITS + 11;
   localparam int DW = ALT_BITS + 1;
   localparam int XW = ((ALT_BITS > 20) ? ALT_BITS : 20) + 2;
   localparam int RW = $clog2(FALL_RUN_LEN + 1);

   fpd_pkg::phase_type          phase_ff, prior_ff;
   fpd_pkg::phase_type          target;
   logic signed [ALT_BITS-1:0]  peak_ff, last_ff, last_in;
   logic [RW-1:0]               run_ff, run_in, run_inc;
   logic [31:0]                 apo_ff, apo_in, lstamp_ff, lstamp_in, stamp_eff;
   logic                        ltiming_ff, ltiming_in;
   logic                        pdone_ff, pdone_in, rdone_ff, rdone_in;
   logic                        take, set_apo;

   logic signed [ALT_BITS-1:0]  peak_new;
   logic signed [PW-1:0]        peak_x, perm_x, peak_scaled;
   logic signed [DW-1:0]        rise, fall;
   logic signed [XW-1:0]        alt_x, launch_x, lo_x, hi_x, landed_x;
   logic                        pay_ok, prb_ok, stable, apo_due, land_due;

   // peak first takes this sample, the payload test uses the new peak
   assign peak_new    = (alt > peak_ff) ? alt : peak_ff;
   assign peak_x      = PW'(peak_new);
   assign perm_x      = PW'($signed({1'b0, cfg.permille}));
   assign peak_scaled = peak_x * perm_x;
   assign pay_ok      = alt_k <= peak_scaled;

   assign rise = DW'(alt) - DW'(last_ff);
   assign fall = DW'(last_ff) - DW'(alt);
   assign stable = (rise < $signed(DW'(fpd_pkg::STABLE_CM)))
                && (fall < $signed(DW'(fpd_pkg::STABLE_CM)));

   assign alt_x    = XW'(alt);
   assign launch_x = XW'($signed({1'b0, cfg.launch_cm}));
   assign landed_x = XW'($signed({1'b0, cfg.landed_cm}));
   assign lo_x     = XW'($signed({1'b0, cfg.probe_tgt_cm}))
                   - XW'($signed({1'b0, cfg.probe_mrg_cm}));
   assign hi_x     = XW'($signed({1'b0, cfg.probe_tgt_cm}))
                   + XW'($signed({1'b0, cfg.probe_mrg_cm}));
   assign prb_ok   = (alt_x >= lo_x) && (alt_x <= hi_x);

   assign run_inc   = run_ff + RW'(1);
   assign apo_due   = (now - apo_ff) >= cfg.apogee_win_ms;
   // landing timer starts on this sample when not yet running
   assign stamp_eff = ltiming_ff ? lstamp_ff : now;
   assign land_due  = (now - stamp_eff) >= cfg.landed_win_ms;

   always_comb begin
      phase_in   = phase_ff;
      prior_in   = prior_ff;
      peak_in    = peak_ff;
      last_in    = last_ff;
      run_in     = run_ff;
      apo_in     = apo_ff;
      lstamp_in  = lstamp_ff;
      ltiming_in = ltiming_ff;
      pdone_in   = pdone_ff;
      rdone_in   = rdone_ff;
      changed_in = 1'b0;
      pay_in     = 1'b0;
      prb_in     = 1'b0;
      take       = 1'b0;
      set_apo    = 1'b0;
      target     = phase_ff;

      if (mode) begin
         // code seven is no phase: item ignored
         if (forced <= 3'(fpd_pkg::PH_LANDED)) begin
            take   = 1'b1;
            target = fpd_pkg::phase_type'(forced);
         end
      end else if (cfg.armed) begin
         peak_in = peak_new;
         last_in = alt;
         case (phase_ff)
            fpd_pkg::PH_PAD: begin
               if ((alt_x >= launch_x) && (rise > $signed(DW'(fpd_pkg::RISE_CM)))) begin
                  take   = 1'b1;
                  target = fpd_pkg::PH_ASCENT;
               end
            end
            fpd_pkg::PH_ASCENT: begin
               if (fall > $signed(DW'(fpd_pkg::FALL_CM))) begin
                  run_in = run_inc;
                  if (run_inc >= RW'(FALL_RUN_LEN)) begin
                     take    = 1'b1;
                     target  = fpd_pkg::PH_APOGEE;
                     set_apo = 1'b1;
                  end
               end else begin
                  run_in = '0;
               end
            end
            fpd_pkg::PH_APOGEE: begin
               if (apo_due) begin
                  take   = 1'b1;
                  target = fpd_pkg::PH_DESCENT;
               end
            end
            fpd_pkg::PH_DESCENT: begin
               if (!pdone_ff && pay_ok) begin
                  take     = 1'b1;
                  target   = fpd_pkg::PH_PAYLOAD;
                  pdone_in = 1'b1;
                  pay_in   = 1'b1;
               end
            end
            fpd_pkg::PH_PAYLOAD: begin
               if (!rdone_ff && prb_ok) begin
                  take     = 1'b1;
                  target   = fpd_pkg::PH_PROBE;
                  rdone_in = 1'b1;
                  prb_in   = 1'b1;
               end
            end
            fpd_pkg::PH_PROBE: begin
               if (alt_x < landed_x) begin
                  if (stable) begin
                     ltiming_in = 1'b1;
                     lstamp_in  = stamp_eff;
                     if (land_due) begin
                        take   = 1'b1;
                        target = fpd_pkg::PH_LANDED;
                     end
                  end else begin
                     ltiming_in = 1'b0;
                     lstamp_in  = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // a transition clears the per-phase trackers
      if (take && (target != phase_ff)) begin
         prior_in   = phase_ff;
         phase_in   = target;
         run_in     = '0;
         apo_in     = '0;
         lstamp_in  = '0;
         ltiming_in = 1'b0;
         changed_in = 1'b1;
      end
      if (set_apo) begin
         apo_in = now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= fpd_pkg::PH_PAD;
         prior_ff   <= fpd_pkg::PH_PAD;
         peak_ff    <= '0;
         last_ff    <= '0;
         run_ff     <= '0;
         apo_ff     <= '0;
         lstamp_ff  <= '0;
         ltiming_ff <= 1'b0;
         pdone_ff   <= 1'b0;
         rdone_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         prior_ff   <= prior_in;
         peak_ff    <= peak_in;
         last_ff    <= last_in;
         run_ff     <= run_in;
         apo_ff     <= apo_in;
         lstamp_ff  <= lstamp_in;
         ltiming_ff <= ltiming_in;
         pdone_ff   <= pdone_in;
         rdone_ff   <= rdone_in;
      end
   end

endmodule

[rtl/core/flight_phase_detector.sv]
// Top level of the flight phase detector: input register, result register, handshakes.
// Depends on fpd_pkg, fpd_csr, fpd_step and flight_phase_detector_macros.svh.
//
// Flight phase detector. Tracks pad, ascent, apogee, descent, payload release,
// probe release and landed from relative altitude samples (cm) with wrapping
// millisecond timestamps. A word on req_ is either an altitude sample
// (req_mode 0, processed only while the armed register is set) or a force word
// (req_mode 1) that sets the phase to req_forced_phase unless it is code seven.
// Every accepted word yields exactly one rsp_ word with the phase after it, the
// phase before the latest transition, change/fire flags and the peak altitude.
// Rate: one word per clock cycle sustained while rsp_ready stays high. The
// accepting edge loads the word into the input register (the altitude is
// scaled by 1000 on the way in). Once the result register is free or being
// drained, the step rule runs against the flight state and writes the result
// register, which drives rsp_valid. The step rule's payload test (new peak
// times permille, compared with the scaled sample) sets the cycle time. The
// input side keeps accepting while a result waits as long as the input register
// can move on into the result register. Configuration is to be written through
// csr_ only while no word is in flight; the block itself does not enforce this.
`include "flight_phase_detector_macros.svh"

module flight_phase_detector #(
   parameter int ALT_BITS     = fpd_pkg::ALT_BITS_DEF,
   parameter int FALL_RUN_LEN = fpd_pkg::FALL_RUN_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample / force words
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic signed [ALT_BITS-1:0]        req_altitude_cm,
   input  logic [31:0]                       req_time_ms,
   input  logic [2:0]                        req_forced_phase,
   // result words
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_phase,
   output logic [2:0]                        rsp_last_phase,
   output logic                              rsp_phase_changed,
   output logic                              rsp_payload_fire,
   output logic                              rsp_probe_fire,
   output logic signed [ALT_BITS-1:0]        rsp_peak_altitude_cm,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fpd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [fpd_pkg::CSR_DATA_BITS-1:0] csr_data
);

   localparam int PW = ALT_BITS + 11;

   fpd_pkg::cfg_type cfg;

   // input register
   logic                       in_valid_ff, in_valid_in;
   logic                       in_mode_ff;
   logic signed [ALT_BITS-1:0] in_alt_ff;
   logic signed [PW-1:0]       in_altk_ff, in_altk_in;
   logic [31:0]                in_time_ff;
   logic [2:0]                 in_forced_ff;

   // result register
   logic                       out_valid_ff, out_valid_in;
   fpd_pkg::phase_type         out_phase_ff, out_prior_ff;
   logic                       out_changed_ff, out_pay_ff, out_prb_ff;
   logic signed [ALT_BITS-1:0] out_peak_ff;

   // step results
   fpd_pkg::phase_type         phase_in, prior_in;
   logic                       changed_in, pay_in, prb_in;
   logic signed [ALT_BITS-1:0] peak_in;

   logic                       req_take, advance;

   // the held word moves on when the result slot is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // sample times 1000 for the payload test, done ahead of the step rule
   assign in_altk_in = PW'(req_altitude_cm) * PW'(fpd_pkg::PERMILLE_SCALE);

   fpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fpd_step #(
      .ALT_BITS     (ALT_BITS),
      .FALL_RUN_LEN (FALL_RUN_LEN)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .fire       (advance),
      .mode       (in_mode_ff),
      .alt        (in_alt_ff),
      .alt_k      (in_altk_ff),
      .now        (in_time_ff),
      .forced     (in_forced_ff),
      .phase_in   (phase_in),
      .prior_in   (prior_in),
      .changed_in (changed_in),
      .pay_in     (pay_in),
      .prb_in     (prb_in),
      .peak_in    (peak_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff   <= req_mode;
         in_alt_ff    <= req_altitude_cm;
         in_altk_ff   <= in_altk_in;
         in_time_ff   <= req_time_ms;
         in_forced_ff <= req_forced_phase;
      end
      if (advance) begin
         out_phase_ff   <= phase_in;
         out_prior_ff   <= prior_in;
         out_changed_ff <= changed_in;
         out_pay_ff     <= pay_in;
         out_prb_ff     <= prb_in;
         out_peak_ff    <= peak_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_phase            = out_phase_ff;
   assign rsp_last_phase       = out_prior_ff;
   assign rsp_phase_changed    = out_changed_ff;
   assign rsp_payload_fire     = out_pay_ff;
   assign rsp_probe_fire       = out_prb_ff;
   assign rsp_peak_altitude_cm = out_peak_ff;

   // a release always comes with the move into its phase
   `FPD_ASSERT_IMPL(a_pay_phase, rsp_valid && rsp_payload_fire,
      rsp_phase_changed && (rsp_phase == 3'(fpd_pkg::PH_PAYLOAD)))
   `FPD_ASSERT_IMPL(a_prb_phase, rsp_valid && rsp_probe_fire,
      rsp_phase_changed && (rsp_phase == 3'(fpd_pkg::PH_PROBE)))
   // a reported change never lands on the phase it left
   `FPD_ASSERT_IMPL(a_change_diff, rsp_valid && rsp_phase_changed,
      rsp_phase != rsp_last_phase)
   // a blocked word in the input register is not lost or overwritten
   `FPD_ASSERT_NEXT(a_in_hold, in_valid_ff && !advance,
      in_valid_ff && $stable(in_time_ff) && $stable(in_alt_ff))

endmodule

[bench/testbench.sv]
// Self-checking bench for flight_phase_detector: drives sample and force words,
// predicts every result word and checks it. Depends on fpd_pkg and the RTL.
module testbench;
   import fpd_pkg::*;

   localparam int ALT_W = ALT_BITS_DEF;
   localparam logic [2:0] PHASE_UNUSED = 3'd7;  // code with no phase behind it
   localparam int HOLDOFF_CYCLES = 80;          // long receiver hold-off
   localparam int QUIET_LIMIT = 2000;           // cycles with no handshake at all
   localparam int PHASE_WORDS = 155;            // random words per armed phase

   typedef struct {
      logic             mode;
      logic [ALT_W-1:0] alt;
      logic [31:0]      stamp;
      logic [2:0]       forced;
   } req_word_type;

   typedef struct {
      phase_type        phase;
      phase_type        last_phase;
      logic             changed;
      logic             payload;
      logic             probe;
      logic [ALT_W-1:0] peak;
   } rsp_word_type;

   logic clock;
   logic reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_mode = 1'b0;
   logic [ALT_W-1:0] req_altitude_cm = '0;
   logic [31:0]      req_time_ms = '0;
   logic [2:0]       req_forced_phase = '0;

   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [2:0]       rsp_phase;
   logic [2:0]       rsp_last_phase;
   logic             rsp_phase_changed;
   logic             rsp_payload_fire;
   logic             rsp_probe_fire;
   logic [ALT_W-1:0] rsp_peak_altitude_cm;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   flight_phase_detector dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_altitude_cm      (req_altitude_cm),
      .req_time_ms          (req_time_ms),
      .req_forced_phase     (req_forced_phase),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_phase            (rsp_phase),
      .rsp_last_phase       (rsp_last_phase),
      .rsp_phase_changed    (rsp_phase_changed),
      .rsp_payload_fire     (rsp_payload_fire),
      .rsp_probe_fire       (rsp_probe_fire),
      .rsp_peak_altitude_cm (rsp_peak_altitude_cm),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // words waiting to be sent, and results owed by the block, oldest first
   req_word_type pending_words[$];
   rsp_word_type expected_reports[$];
   int           words_queued = 0;
   int           error_count = 0;

   // idling knobs, set only at the falling edge, then the hold-off and quiet counters
   int send_idle_pct = 0;
   int stall_pct = 0;
   int holdoff_asked = 0;
   int holdoff_seen = 0;
   int holdoff_left = 0;
   int quiet_cycles = 0;

   // shadow of the registers plus the flight state, as the block should hold them
   cfg_type     flight_cfg = CFG_RESET;
   phase_type   cur_phase = PH_PAD;
   phase_type   held_phase = PH_PAD;
   longint      peak_cm = 0;
   longint      prev_cm = 0;
   int unsigned fall_count = 0;
   logic [31:0] apogee_mark = '0;
   logic [31:0] landing_mark = '0;
   bit          landing_clock_on = 1'b0;
   bit          payload_spent = 1'b0;
   bit          probe_spent = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Flight state prediction
   // ---------------------------------------------------------------------

   // Moving to the phase already held is a no-op; otherwise the run and
   // timer state starts over.
   function automatic bit shift_phase(phase_type nxt);
      if (nxt == cur_phase) return 1'b0;
      held_phase = cur_phase;
      cur_phase = nxt;
      fall_count = 0;
      apogee_mark = '0;
      landing_mark = '0;
      landing_clock_on = 1'b0;
      return 1'b1;
   endfunction

   function automatic rsp_word_type advance_flight(req_word_type w);
      rsp_word_type r;
      longint cur, lo, hi, d, launch, permille, landed;
      logic [31:0] span;
      bit moved, pay, prb;
      cur = $signed(w.alt);
      launch = flight_cfg.launch_cm;
      permille = flight_cfg.permille;
      landed = flight_cfg.landed_cm;
      lo = longint'(flight_cfg.probe_tgt_cm) - longint'(flight_cfg.probe_mrg_cm);
      hi = longint'(flight_cfg.probe_tgt_cm) + longint'(flight_cfg.probe_mrg_cm);
      moved = 1'b0;
      pay = 1'b0;
      prb = 1'b0;
      if (w.mode) begin
         // force word: acts armed or not, code seven is ignored
         if (w.forced != PHASE_UNUSED) moved = shift_phase(phase_type'(w.forced));
      end else if (flight_cfg.armed) begin
         if (cur > peak_cm) peak_cm = cur;
         case (cur_phase)
            PH_PAD: begin
               if (cur >= launch && cur - prev_cm > RISE_CM) moved = shift_phase(PH_ASCENT);
            end
            PH_ASCENT: begin
               if (prev_cm - cur > FALL_CM) begin
                  fall_count++;
                  if (fall_count >= FALL_RUN_LEN_DEF) begin
                     moved = shift_phase(PH_APOGEE);
                     apogee_mark = w.stamp;
                  end
               end else begin
                  fall_count = 0;
               end
            end
            PH_APOGEE: begin
               span = w.stamp - apogee_mark;
               if (span >= flight_cfg.apogee_win_ms) moved = shift_phase(PH_DESCENT);
            end
            PH_DESCENT: begin
               if (!payload_spent && cur * PERMILLE_SCALE <= peak_cm * permille) begin
                  moved = shift_phase(PH_PAYLOAD);
                  payload_spent = 1'b1;
                  pay = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               if (!probe_spent && cur >= lo && cur <= hi) begin
                  moved = shift_phase(PH_PROBE);
                  probe_spent = 1'b1;
                  prb = 1'b1;
               end
            end
            PH_PROBE: begin
               if (cur < landed) begin
                  d = cur - prev_cm;
                  if (d < 0) d = -d;
                  if (d < STABLE_CM) begin
                     if (!landing_clock_on) begin
                        landing_clock_on = 1'b1;
                        landing_mark = w.stamp;
                     end
                     span = w.stamp - landing_mark;
                     if (span >= flight_cfg.landed_win_ms) moved = shift_phase(PH_LANDED);
                  end else begin
                     landing_clock_on = 1'b0;
                     landing_mark = '0;
                  end
               end
            end
            default: ;
         endcase
         prev_cm = cur;
      end
      r.phase = cur_phase;
      r.last_phase = held_phase;
      r.changed = moved;
      r.payload = pay;
      r.probe = prb;
      r.peak = ALT_W'(peak_cm);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: presents the oldest pending word; valid holds until taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_reports.push_back(advance_flight(pending_words.pop_front()));
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_mode <= pending_words[0].mode;
               req_altitude_cm <= pending_words[0].alt;
               req_time_ms <= pending_words[0].stamp;
               req_forced_phase <= pending_words[0].forced;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_left != 0) begin
         rsp_ready <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_seen != holdoff_asked) begin
         holdoff_seen <= holdoff_asked;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   function automatic void compare_field(string name, logic [ALT_W-1:0] want,
                                         logic [ALT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
         error_count++;
      end
   endfunction

   // result checker: every result word against the oldest expectation
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: result word with nothing expected", $time);
            error_count++;
         end else begin
            want = expected_reports.pop_front();
            compare_field("phase", ALT_W'(want.phase), ALT_W'(rsp_phase));
            compare_field("last_phase", ALT_W'(want.last_phase), ALT_W'(rsp_last_phase));
            compare_field("phase_changed", ALT_W'(want.changed), ALT_W'(rsp_phase_changed));
            compare_field("payload_fire", ALT_W'(want.payload), ALT_W'(rsp_payload_fire));
            compare_field("probe_fire", ALT_W'(want.probe), ALT_W'(rsp_probe_fire));
            compare_field("peak_altitude_cm", want.peak, rsp_peak_altitude_cm);
         end
      end
   end

   // watchdog: ends a hung run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic longint clamp_alt(longint v);
      longint top = (longint'(1) << (ALT_W - 1)) - 1;
      if (v > top) return top;
      if (v < -top - 1) return -top - 1;
      return v;
   endfunction

   function automatic void push_word(req_word_type w);
      pending_words.push_back(w);
      words_queued++;
   endfunction

   function automatic void push_at(longint alt, logic [31:0] t);
      req_word_type w;
      w.mode = 1'b0;
      w.alt = ALT_W'(clamp_alt(alt));
      w.stamp = t;
      w.forced = 3'($urandom_range(0, 7));
      push_word(w);
   endfunction

   // other fields random: the block must ignore them
   function automatic void push_force(logic [2:0] ph);
      req_word_type w;
      w.mode = 1'b1;
      w.alt = ALT_W'($urandom);
      w.stamp = $urandom;
      w.forced = ph;
      push_word(w);
   endfunction

   // sample inside a flight, now and then preceded by a fully random word
   function automatic void push_sample(longint alt, logic [31:0] t);
      req_word_type w;
      if ($urandom_range(0, 99) < 6) begin
         w.mode = ($urandom_range(0, 3) == 0);
         w.alt = ALT_W'($urandom);
         w.stamp = $urandom;
         w.forced = 3'($urandom_range(0, 7));
         push_word(w);
      end
      push_at(alt, t);
   endfunction

   // One well-formed flight under the current settings, random content:
   // pad, climb, falling run, apogee window, descent into the probe window,
   // stable low samples through the landing window, then a force to the pad (now and then to a random phase).
   task automatic queue_flight();
      longint alt, goal, step, base, tgt, mrg;
      logic [31:0] t, mark;
      int k, good;
      tgt = flight_cfg.probe_tgt_cm;
      mrg = flight_cfg.probe_mrg_cm;
      t = $urandom;
      alt = longint'($urandom_range(0, 200)) - 100;
      repeat ($urandom_range(1, 3)) begin
         t += $urandom_range(1, 500);
         push_sample(alt, t);
      end
      goal = clamp_alt(longint'(flight_cfg.launch_cm) + longint'($urandom_range(60, 30000)));
      k = $urandom_range(1, 5);
      step = (goal - alt) / k;
      for (int i = 1; i < k; i++) begin
         alt += step;
         t += $urandom_range(1, 500);
         push_sample(alt, t);
      end
      alt = goal;
      t += $urandom_range(1, 500);
      push_sample(alt, t);
      // falling run; a shallow drop now and then restarts it
      good = 0;
      while (good < FALL_RUN_LEN_DEF) begin
         if ($urandom_range(0, 9) == 0) begin
            alt = clamp_alt(alt - longint'($urandom_range(0, 50)));
            good = 0;
         end else begin
            alt = clamp_alt(alt - longint'($urandom_range(51, 600)));
            good++;
         end
         t += $urandom_range(1, 500);
         push_sample(alt, t);
      end
      // apogee window: one short of it, then on or just past it
      mark = t;
      if ($urandom_range(0, 1)) push_sample(alt - 10, mark + flight_cfg.apogee_win_ms - 1);
      t = mark + flight_cfg.apogee_win_ms + $urandom_range(0, 2);
      push_sample(alt - 20, t);
      alt = clamp_alt(alt - 20);
      // descent down into the probe window
      base = clamp_alt(tgt - mrg + longint'($urandom_range(0, 32'(2 * mrg))));
      k = $urandom_range(1, 4);
      step = (base - alt) / k;
      for (int i = 1; i < k; i++) begin
         alt += step;
         t += $urandom_range(1, 500);
         push_sample(alt, t);
      end
      alt = base;
      repeat (2) begin
         t += $urandom_range(1, 500);
         push_sample(alt, t);
      end
      // release flags never rearm, so later flights often need the jump
      if ($urandom_range(0, 9) < 6) push_force(PH_PROBE);
      // landing: low and steady, now and then with a disturbance that stops the timer
      base = clamp_alt(longint'(flight_cfg.landed_cm) - longint'($urandom_range(21, 300)));
      t += $urandom_range(1, 500);
      push_sample(base, t);
      if ($urandom_range(0, 2) == 0) begin
         t += $urandom_range(1, 500);
         push_sample(base - 40, t);
         t += $urandom_range(1, 500);
         push_sample(base, t);
      end
      t += $urandom_range(1, 500);
      push_sample(base + 5, t);
      mark = t;
      if (flight_cfg.landed_win_ms != 0 && $urandom_range(0, 1))
         push_sample(base, mark + flight_cfg.landed_win_ms - 1);
      push_sample(base + 10, mark + flight_cfg.landed_win_ms);
      t = mark + flight_cfg.landed_win_ms + $urandom_range(1, 500);
      push_sample(longint'($urandom_range(0, 2000)), t);
      if ($urandom_range(0, 3) == 0) push_force(3'($urandom_range(0, 6)));
      else push_force(PH_PAD);
   endtask

   // all words sent and all results back; call at the falling edge
   task automatic wait_drain();
      while (pending_words.size() != 0 || expected_reports.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_ARMED:    flight_cfg.armed = val[0];
         REG_LAUNCH:   flight_cfg.launch_cm = val[18:0];
         REG_APO_WIN:  flight_cfg.apogee_win_ms = val;
         REG_PERMILLE: flight_cfg.permille = val[9:0];
         REG_PRB_TGT:  flight_cfg.probe_tgt_cm = val[18:0];
         REG_PRB_MRG:  flight_cfg.probe_mrg_cm = val[18:0];
         REG_LAND_ALT: flight_cfg.landed_cm = val[18:0];
         REG_LAND_WIN: flight_cfg.landed_win_ms = val;
         default: ;
      endcase
   endtask

   // phase 1 takes every register but armed low, phase 2 high, phase 5 runs unarmed
   task automatic load_settings(int p);
      logic [31:0] v [8];
      v[REG_ARMED] = (p != 5);
      v[REG_LAUNCH] = $urandom_range(0, 20000);
      v[REG_APO_WIN] = $urandom_range(0, 5000);
      v[REG_PERMILLE] = $urandom_range(0, 1023);
      v[REG_PRB_TGT] = $urandom_range(0, 3000);
      v[REG_PRB_MRG] = $urandom_range(0, 500);
      v[REG_LAND_ALT] = $urandom_range(0, 3000);
      v[REG_LAND_WIN] = $urandom_range(0, 6000);
      if (p == 1) begin
         for (int i = 1; i < 8; i++) v[i] = '0;
      end else if (p == 2) begin
         v[REG_LAUNCH] = 19'h7FFFF;
         v[REG_APO_WIN] = 32'hFFFF_FFFF;
         v[REG_PERMILLE] = 10'h3FF;
         v[REG_PRB_TGT] = 19'h7FFFF;
         v[REG_PRB_MRG] = 19'h7FFFF;
         v[REG_LAND_ALT] = 19'h7FFFF;
         v[REG_LAND_WIN] = 32'hFFFF_FFFF;
      end
      for (int i = 0; i < 8; i++) write_reg(csr_reg_type'(i), v[i]);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // still disarmed: a sample is ignored, force code seven too
      push_at(5000, 100);
      push_force(PHASE_UNUSED);
      wait_drain();
      repeat (4) @(posedge clock);
      write_reg(REG_ARMED, 1);
      @(negedge clock);

      // full flight at reset settings, each threshold hit on its edge
      push_at(0, 1000);
      push_at(1200, 1100);         // launch
      push_at(5000, 1200);
      push_at(4949, 1300);         // drop of 51 counts
      push_at(4899, 1400);         // drop of exactly 50 breaks the run
      push_at(4800, 1500);
      push_at(4700, 1600);
      push_at(4600, 1700);         // third drop in a row: apogee
      push_at(4500, 3699);         // one short of the window
      push_at(4400, 3700);         // descent
      push_at(4001, 3800);         // just above the release fraction
      push_at(4000, 3900);         // payload release on equality
      push_at(251, 4000);          // one above the probe window
      push_at(250, 4100);          // probe release on the window edge
      push_at(100, 4200);          // big change: timer stays off
      push_at(71, 4300);           // change of 29 starts the timer
      push_at(100, 7299);
      push_at(99, 7300);           // landed after exactly the window
      push_at(-524288, 32'hFFFF_FFFF);  // landed holds
      push_force(PH_APOGEE);       // forced apogee counts from time zero
      push_at(524287, 1999);
      push_at(0, 2000);            // descent; payload already spent
      push_force(PH_PAD);

      for (int p = 0; p < 8; p++) begin
         wait_drain();
         repeat (4) @(posedge clock);
         load_settings(p);
         @(negedge clock);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 47; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 47; end
            default: begin send_idle_pct = 7; stall_pct = 7; end
         endcase
         start = words_queued;
         while (words_queued - start < ((p == 5) ? 20 : PHASE_WORDS / 2)) queue_flight();
         // receiver holds off while words keep coming: the block fills up
         if (p == 0) holdoff_asked++;
         // sender pauses until the block has handed back everything
         if (p == 4) wait_drain();
         while (words_queued - start < ((p == 5) ? 40 : PHASE_WORDS)) queue_flight();
      end

      wait_drain();
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
